@@ hdl/nnfd_pkg.sv @@
package nnfd_pkg;

  // default largest frame dimension
  localparam int MAX_DIM_DEF = 8192;

  // configuration port
  localparam int CFG_W     = 14;
  localparam int CFG_IDX_W = 3;

  // payload widths
  localparam int PIX_W       = 32;
  localparam int COORD_W     = 13;
  localparam int FNUM_W      = 32;
  localparam int OUT_FIELD_W = PIX_W + 2 * COORD_W + 1 + FNUM_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // register reset values
  localparam logic [CFG_W-1:0] SRC_WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] SRC_HEIGHT_RST = CFG_W'(1080);
  localparam logic [CFG_W-1:0] PITCH_RST      = CFG_W'(1920);
  localparam logic [CFG_W-1:0] TGT_WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] TGT_HEIGHT_RST = CFG_W'(1080);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SRC_WIDTH  = 3'd0,
    REG_SRC_HEIGHT = 3'd1,
    REG_ROW_PITCH  = 3'd2,
    REG_TGT_WIDTH  = 3'd3,
    REG_TGT_HEIGHT = 3'd4
  } cfg_reg_t;

  // settings as seen by the selection logic
  typedef struct packed {
    logic [CFG_W-1:0] src_width;
    logic [CFG_W-1:0] src_height;
    logic [CFG_W-1:0] pitch;       // clamped to [src_width, max dim]
    logic [CFG_W-1:0] tgt_width;
    logic [CFG_W-1:0] tgt_height;
    logic             sizes_bad;
  } cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic               frame_start;
  } item_t;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
    logic               buffer_slot;
    logic [FNUM_W-1:0]  frame_number;
    logic               frame_done;
    logic               size_error;
  } result_t;

endpackage

@@ hdl/nearest_neighbor_frame_downscaler.sv @@
// path: an input transfer loads the input register, then the selection logic writes
//   its result into the result register that drives out_*
// throughput: one pixel per cycle while the result register is not held by out_tready
// reset: synchronous active-low rst_n clears positions, frame counter and both stage
//   valids, and loads the configuration registers with their defaults
module nearest_neighbor_frame_downscaler #(
  parameter int MAX_DIM = nnfd_pkg::MAX_DIM_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // source pixel stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [nnfd_pkg::PIX_W-1:0]       in_tdata,   // [31:0] pixel_word
  input  logic                             in_tuser,   // [0] frame_start
  // kept pixel stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] out_pixel, [44:32] dest_x, [57:45] dest_y, [58] buffer_slot,
  // [90:59] frame_number, upper bits zero
  output logic [nnfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tlast,  // frame_done
  output logic                             out_tuser,  // [0] size_error
  // register writes
  input  logic                             cfg_wr_en,
  input  logic [nnfd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [nnfd_pkg::CFG_W-1:0]       cfg_wdata
);

  nnfd_pkg::cfg_t    cfg;
  nnfd_pkg::item_t   item_r;
  nnfd_pkg::result_t res;
  logic              item_vld_r;
  logic              sel_rdy;

  // input register: refills whenever its item moves on to the selection logic
  assign in_tready = !item_vld_r || sel_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_tready) begin
      item_vld_r <= in_tvalid;
    end
  end

  // payload needs no reset, load only on a transfer
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.pixel       <= in_tdata;
      item_r.frame_start <= in_tuser;
    end
  end

  // sizes, pitch clamp and the unsupported-size check
  nnfd_cfg_regs #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // nearest-neighbor pick with exact accumulators, result register inside
  nnfd_select #(
    .MAX_DIM (MAX_DIM)
  ) u_select (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .item_vld (item_vld_r),
    .item     (item_r),
    .item_rdy (sel_rdy),
    .res_vld  (out_tvalid),
    .res      (res),
    .res_rdy  (out_tready)
  );

  // pack result fields, lowest field first
  assign out_tdata = nnfd_pkg::OUT_TDATA_W'({res.frame_number, res.buffer_slot,
                                             res.dest_y, res.dest_x, res.pixel});
  assign out_tlast = res.frame_done;
  assign out_tuser = res.size_error;

endmodule

@@ hdl/nnfd_cfg_regs.sv @@
module nnfd_cfg_regs #(
  parameter int MAX_DIM = nnfd_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [nnfd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [nnfd_pkg::CFG_W-1:0]     cfg_wdata,
  output nnfd_pkg::cfg_t                 cfg
);

  localparam int CMP_W = nnfd_pkg::CFG_W + 1;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_DIM);

  logic [nnfd_pkg::CFG_W-1:0] src_width_r, src_height_r, pitch_r;
  logic [nnfd_pkg::CFG_W-1:0] tgt_width_r, tgt_height_r;

  logic [CMP_W-1:0] sw_x, sh_x, tw_x, th_x, pitch_x, pitch_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_width_r  <= nnfd_pkg::SRC_WIDTH_RST;
      src_height_r <= nnfd_pkg::SRC_HEIGHT_RST;
      pitch_r      <= nnfd_pkg::PITCH_RST;
      tgt_width_r  <= nnfd_pkg::TGT_WIDTH_RST;
      tgt_height_r <= nnfd_pkg::TGT_HEIGHT_RST;
    end else if (cfg_wr_en) begin
      case (nnfd_pkg::cfg_reg_t'(cfg_addr))
        nnfd_pkg::REG_SRC_WIDTH:  src_width_r  <= cfg_wdata;
        nnfd_pkg::REG_SRC_HEIGHT: src_height_r <= cfg_wdata;
        nnfd_pkg::REG_ROW_PITCH:  pitch_r      <= cfg_wdata;
        nnfd_pkg::REG_TGT_WIDTH:  tgt_width_r  <= cfg_wdata;
        nnfd_pkg::REG_TGT_HEIGHT: tgt_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    sw_x    = {1'b0, src_width_r};
    sh_x    = {1'b0, src_height_r};
    tw_x    = {1'b0, tgt_width_r};
    th_x    = {1'b0, tgt_height_r};
    pitch_x = {1'b0, pitch_r};

    pitch_c = (pitch_x < sw_x) ? sw_x : pitch_x;
    if (pitch_c > MAX_C) begin
      pitch_c = MAX_C;
    end

    cfg.src_width  = src_width_r;
    cfg.src_height = src_height_r;
    cfg.tgt_width  = tgt_width_r;
    cfg.tgt_height = tgt_height_r;
    cfg.pitch      = pitch_c[nnfd_pkg::CFG_W-1:0];
    cfg.sizes_bad  = (sw_x == '0) || (sh_x == '0) || (tw_x == '0) || (th_x == '0) ||
                     (sw_x > MAX_C) || (sh_x > MAX_C) ||
                     (tw_x > sw_x) || (th_x > sh_x);
  end

endmodule

@@ hdl/nnfd_select.sv @@
module nnfd_select #(
  parameter int MAX_DIM = nnfd_pkg::MAX_DIM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  nnfd_pkg::cfg_t      cfg,
  input  logic                item_vld,
  input  nnfd_pkg::item_t     item,
  output logic                item_rdy,
  output logic                res_vld,
  output nnfd_pkg::result_t   res,
  input  logic                res_rdy
);

  localparam int COL_W = $clog2(MAX_DIM);
  localparam int POS_W = $clog2(MAX_DIM + 1);
  localparam int ACC_W = $clog2(MAX_DIM * MAX_DIM + MAX_DIM + 1);

  logic [COL_W-1:0] src_col_r, src_col_nxt, src_col_c;
  logic [POS_W-1:0] src_row_r, src_row_nxt, src_row_c;
  logic [POS_W-1:0] dst_col_r, dst_col_nxt, dst_col_c;
  logic [POS_W-1:0] dst_row_r, dst_row_nxt, dst_row_c;
  logic [ACC_W-1:0] col_tacc_r, col_tacc_nxt, col_tacc_c;
  logic [ACC_W-1:0] col_sacc_r, col_sacc_nxt, col_sacc_c;
  logic [ACC_W-1:0] row_tacc_r, row_tacc_nxt, row_tacc_c;
  logic [ACC_W-1:0] row_sacc_r, row_sacc_nxt, row_sacc_c;
  logic [nnfd_pkg::FNUM_W-1:0] frame_cnt_r, frame_cnt_nxt;
  logic err_sent_r, err_sent_nxt, err_c;

  logic res_vld_r;
  nnfd_pkg::result_t res_r, res_nxt;

  logic [POS_W-1:0] sw, sh, tw, th, pitch, src_col_inc;
  logic row_pick, col_pick, done, emit, fire;

  assign item_rdy = !res_vld_r || res_rdy;
  assign fire     = item_vld && item_rdy;
  assign res_vld  = res_vld_r;
  assign res      = res_r;

  always_comb begin
    sw    = POS_W'(cfg.src_width);
    sh    = POS_W'(cfg.src_height);
    tw    = POS_W'(cfg.tgt_width);
    th    = POS_W'(cfg.tgt_height);
    pitch = POS_W'(cfg.pitch);

    // frame start restarts the position before the word is handled
    src_col_c  = item.frame_start ? '0 : src_col_r;
    src_row_c  = item.frame_start ? '0 : src_row_r;
    dst_col_c  = item.frame_start ? '0 : dst_col_r;
    dst_row_c  = item.frame_start ? '0 : dst_row_r;
    col_tacc_c = item.frame_start ? '0 : col_tacc_r;
    col_sacc_c = item.frame_start ? '0 : col_sacc_r;
    row_tacc_c = item.frame_start ? '0 : row_tacc_r;
    row_sacc_c = item.frame_start ? '0 : row_sacc_r;
    err_c      = item.frame_start ? 1'b0 : err_sent_r;

    src_col_nxt   = src_col_c;
    src_row_nxt   = src_row_c;
    dst_col_nxt   = dst_col_c;
    dst_row_nxt   = dst_row_c;
    col_tacc_nxt  = col_tacc_c;
    col_sacc_nxt  = col_sacc_c;
    row_tacc_nxt  = row_tacc_c;
    row_sacc_nxt  = row_sacc_c;
    err_sent_nxt  = err_c;
    frame_cnt_nxt = frame_cnt_r;
    emit          = 1'b0;

    row_pick = (dst_row_c < th) && (row_tacc_c < row_sacc_c + ACC_W'(th));
    col_pick = (POS_W'(src_col_c) < sw) && (dst_col_c < tw) &&
               (col_tacc_c < col_sacc_c + ACC_W'(tw));
    done     = (dst_col_c == tw - POS_W'(1)) && (dst_row_c == th - POS_W'(1));
    src_col_inc = POS_W'(src_col_c) + POS_W'(1);

    res_nxt.pixel        = item.pixel;
    res_nxt.dest_x       = nnfd_pkg::COORD_W'(dst_col_c);
    res_nxt.dest_y       = nnfd_pkg::COORD_W'(dst_row_c);
    res_nxt.buffer_slot  = frame_cnt_r[0];
    res_nxt.frame_number = frame_cnt_r;
    res_nxt.frame_done   = done;
    res_nxt.size_error   = 1'b0;

    if (cfg.sizes_bad) begin
      // one error result per frame, the rest of the frame is dropped
      if (!err_c) begin
        emit                = 1'b1;
        res_nxt.pixel       = '0;
        res_nxt.dest_x      = '0;
        res_nxt.dest_y      = '0;
        res_nxt.frame_done  = 1'b0;
        res_nxt.size_error  = 1'b1;
        err_sent_nxt        = 1'b1;
        frame_cnt_nxt       = frame_cnt_r + 1'b1;
      end
    end else if (src_row_c < sh) begin
      if (row_pick && col_pick) begin
        emit         = 1'b1;
        dst_col_nxt  = dst_col_c + POS_W'(1);
        col_tacc_nxt = col_tacc_c + ACC_W'(sw);
        if (done) begin
          frame_cnt_nxt = frame_cnt_r + 1'b1;
        end
      end
      col_sacc_nxt = col_sacc_c + ACC_W'(tw);
      if (src_col_inc >= pitch) begin
        src_col_nxt  = '0;
        dst_col_nxt  = '0;
        col_tacc_nxt = '0;
        col_sacc_nxt = '0;
        if (row_pick) begin
          dst_row_nxt  = dst_row_c + POS_W'(1);
          row_tacc_nxt = row_tacc_c + ACC_W'(sh);
        end
        src_row_nxt  = src_row_c + POS_W'(1);
        row_sacc_nxt = row_sacc_c + ACC_W'(th);
      end else begin
        src_col_nxt = src_col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r   <= '0;
      src_row_r   <= '0;
      dst_col_r   <= '0;
      dst_row_r   <= '0;
      col_tacc_r  <= '0;
      col_sacc_r  <= '0;
      row_tacc_r  <= '0;
      row_sacc_r  <= '0;
      frame_cnt_r <= '0;
      err_sent_r  <= 1'b0;
    end else if (fire) begin
      src_col_r   <= src_col_nxt;
      src_row_r   <= src_row_nxt;
      dst_col_r   <= dst_col_nxt;
      dst_row_r   <= dst_row_nxt;
      col_tacc_r  <= col_tacc_nxt;
      col_sacc_r  <= col_sacc_nxt;
      row_tacc_r  <= row_tacc_nxt;
      row_sacc_r  <= row_sacc_nxt;
      frame_cnt_r <= frame_cnt_nxt;
      err_sent_r  <= err_sent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (item_rdy) begin
      res_vld_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      res_r <= res_nxt;
    end
  end

endmodule
